### rtl/bit_vector_rank_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit vector rank engine
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_RANK_ENGINE_TOP_ASSERT_SVH
`define BIT_VECTOR_RANK_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define BVR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bvr assertion failed");

// next-cycle implication
`define BVR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bvr assertion failed");

`endif

### rtl/bvr_pkg.sv
// ----------------------------------------------------------------------------
// bvr_pkg
// Sizes, command codes and sequencer states of the bit vector rank engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bvr_pkg;

  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 16;
  localparam int CAP_BITS  = WORD_BITS * NUM_WORDS;

  localparam int WOFF   = $clog2(WORD_BITS);
  localparam int WIDX   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W  = 11;
  localparam int SLOT_W = 4;
  localparam int CMD_W  = 4;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 11;
  localparam int CAP_W  = $clog2(CAP_BITS + 1);
  localparam int LIM_W  = (POS_W > CAP_W) ? POS_W : CAP_W;

  localparam int IN_FIELDS_W  = CMD_W + POS_W + 1 + SLOT_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + CNT_W + DATA_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET       = 4'd0,
    CMD_SET_BIT   = 4'd1,
    CMD_SET_RANGE = 4'd2,
    CMD_CLEAR_ALL = 4'd3,
    CMD_POPCOUNT  = 4'd4,
    CMD_RANK      = 4'd5,
    CMD_OR_WORD   = 4'd6,
    CMD_XOR_WORD  = 4'd7,
    CMD_READ_WORD = 4'd8
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

### rtl/bit_vector_rank_engine_top.sv
// Bit vector rank engine: holds a 1024-bit vector (16 words of 64 bits), zero
// after reset, and runs one command per request. A request is taken in the
// idle cycle and executed by one shared word unit (mask, merge, popcount and
// accumulate) that touches one store word per cycle, but holds the last word
// while the previous result waits on the output. Get, set bit, or/xor word
// and read word touch a single word. Set range, rank and popcount walk the
// words below their limit; clear all always walks all 16 words. The word walk
// and output back-pressure set the rate. A new request is taken while the
// previous result is still waiting on the output.
// ----------------------------------------------------------------------------
// bit_vector_rank_engine_top
// Bit vector with get, set/clear, range set, word merge and read, popcount and rank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bit_vector_rank_engine_top_assert.svh"

module bit_vector_rank_engine_top
  import bvr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // command[3:0], bit_pos[14:4], bit_value[15], word_index[19:16],
  // word_data[83:20], zero fill above
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // bit_out[0], count_out[11:1], word_out[75:12], range_error[76],
  // zero fill above
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  localparam logic [LIM_W-1:0] CAP_L = LIM_W'(CAP_BITS);

  state_t state, state_next;

  logic [NUM_WORDS-1:0][WORD_BITS-1:0] store;

  cmd_t              cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic              val_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DATA_W-1:0] data_r;
  logic [LIM_W-1:0]  lim_r;
  logic [WIDX-1:0]   w_cnt;
  logic [CNT_W-1:0]  acc;

  logic              bit_o;
  logic [CNT_W-1:0]  count_o;
  logic [DATA_W-1:0] word_o;
  logic              err_o;

  // request fields
  cmd_t              cmd_in;
  logic [POS_W-1:0]  pos_in;
  logic [LIM_W-1:0]  pos_in_ext;
  logic [LIM_W-1:0]  lim_in;

  assign cmd_in     = cmd_t'(s_tdata[CMD_W-1:0]);
  assign pos_in     = s_tdata[CMD_W +: POS_W];
  assign pos_in_ext = LIM_W'(pos_in);

  always_comb begin
    unique case (cmd_in) inside
      CMD_SET_RANGE:               lim_in = pos_in_ext;
      CMD_CLEAR_ALL, CMD_POPCOUNT: lim_in = CAP_L;
      CMD_RANK:                    lim_in = (pos_in_ext > CAP_L) ? CAP_L : pos_in_ext;
      default:                     lim_in = '0;
    endcase
  end

  // word unit
  logic [LIM_W-1:0]     pos_ext;
  logic [WIDX-1:0]      addr;
  logic [WORD_BITS-1:0] rd;
  logic [LIM_W-1:0]     base;
  logic [LIM_W:0]       base_next;
  logic [LIM_W-1:0]     rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] data_w;
  logic [CNT_W-1:0]     pc;
  logic [CNT_W:0]       sum;
  logic [CNT_W-1:0]     sum_sat;
  logic                 last_loop;
  logic                 slot_ok;
  logic                 can_finish;

  assign pos_ext   = LIM_W'(pos_r);
  assign slot_ok   = 32'(slot_r) < NUM_WORDS;
  assign base      = LIM_W'({w_cnt, {WOFF{1'b0}}});
  assign base_next = (LIM_W+1)'(base) + (LIM_W+1)'(WORD_BITS);
  assign rem       = lim_r - base;
  assign mask      = (rem >= LIM_W'(WORD_BITS)) ? '1
                   : ((WORD_BITS'(1) << rem[WOFF-1:0]) - WORD_BITS'(1));
  assign onehot    = WORD_BITS'(1) << pos_r[WOFF-1:0];
  assign data_w    = data_r[WORD_BITS-1:0];
  assign last_loop = (w_cnt == WIDX'(NUM_WORDS - 1)) || ((LIM_W+1)'(lim_r) <= base_next);
  assign can_finish = !m_tvalid || m_tready;

  always_comb begin
    unique case (cmd_r) inside
      CMD_GET, CMD_SET_BIT:                     addr = pos_r[WOFF +: WIDX];
      CMD_OR_WORD, CMD_XOR_WORD, CMD_READ_WORD: addr = slot_r[WIDX-1:0];
      default:                                  addr = w_cnt;
    endcase
  end

  assign rd      = store[addr];
  assign pc      = CNT_W'($countones(rd & mask));
  assign sum     = (CNT_W+1)'(acc) + (CNT_W+1)'(pc);
  assign sum_sat = sum[CNT_W] ? '1 : sum[CNT_W-1:0];

  // per-cycle action
  logic                 fin;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;
  logic                 res_bit;
  logic [CNT_W-1:0]     res_cnt;
  logic [DATA_W-1:0]    res_word;
  logic                 res_err;

  always_comb begin
    fin      = 1'b1;
    we       = 1'b0;
    wdata    = rd;
    res_bit  = 1'b0;
    res_cnt  = '0;
    res_word = '0;
    res_err  = 1'b0;
    unique case (cmd_r) inside
      CMD_GET: begin
        res_bit = (pos_ext < CAP_L) ? rd[pos_r[WOFF-1:0]] : 1'b0;
      end
      CMD_SET_BIT: begin
        if (pos_ext >= CAP_L) begin
          res_err = 1'b1;
        end else begin
          we    = 1'b1;
          wdata = val_r ? (rd | onehot) : (rd & ~onehot);
        end
      end
      CMD_SET_RANGE: begin
        if (pos_ext > CAP_L) begin
          res_err = 1'b1;
        end else if (lim_r != '0) begin
          we    = 1'b1;
          wdata = val_r ? (rd | mask) : (rd & ~mask);
          fin   = last_loop;
        end
      end
      CMD_CLEAR_ALL: begin
        we    = 1'b1;
        wdata = '0;
        fin   = last_loop;
      end
      CMD_POPCOUNT, CMD_RANK: begin
        if (lim_r != '0) begin
          res_cnt = sum_sat;
          fin     = last_loop;
        end
      end
      CMD_OR_WORD, CMD_XOR_WORD: begin
        if (slot_ok) begin
          we       = 1'b1;
          wdata    = (cmd_r == CMD_OR_WORD) ? (rd | data_w) : (rd ^ data_w);
          res_word = DATA_W'(wdata);
        end else begin
          res_err = 1'b1;
        end
      end
      CMD_READ_WORD: begin
        if (slot_ok) begin
          res_word = DATA_W'(rd);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_EXEC;
      S_EXEC: if (fin && can_finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_r  <= cmd_in;
      pos_r  <= pos_in;
      val_r  <= s_tdata[CMD_W + POS_W];
      slot_r <= s_tdata[CMD_W + POS_W + 1 +: SLOT_W];
      data_r <= s_tdata[CMD_W + POS_W + 1 + SLOT_W +: DATA_W];
      lim_r  <= lim_in;
      w_cnt  <= '0;
      acc    <= '0;
    end else if (state == S_EXEC && !fin) begin
      w_cnt <= w_cnt + WIDX'(1);
      acc   <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
    end else if (state == S_EXEC && we && (!fin || can_finish)) begin
      store[addr] <= wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EXEC && fin && can_finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && fin && can_finish) begin
      bit_o   <= res_bit;
      count_o <= res_cnt;
      word_o  <= res_word;
      err_o   <= res_err;
    end
  end

  assign m_tdata = OUT_TDATA_W'({err_o, word_o, count_o, bit_o});

  `BVR_ASSERT_NXT(a_accept_exec, clk, rst, s_tvalid && s_tready, state == S_EXEC)
  `BVR_ASSERT_NXT(a_finish_valid, clk, rst, state == S_EXEC && fin && can_finish, m_tvalid)
  `BVR_ASSERT_NXT(a_idle_store, clk, rst, state == S_IDLE, $stable(store))
  `BVR_ASSERT_IMP(a_count_cap, clk, rst, m_tvalid, 32'(count_o) <= CAP_BITS)

endmodule

`default_nettype wire
